@@ rtl/core/plic_pkg.sv @@
// Shared types and constants of the platform interrupt controller.
// Used by the interfaces, the controller, the datapath and the top level.
package plic_pkg;

    localparam int unsigned ADDR_W = 22;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned SRC_W  = 7;

    localparam logic [ADDR_W-1:0] ENABLE_BASE   = 22'h002080;
    localparam logic [ADDR_W-1:0] CTX_THRESHOLD = 22'h201000;
    localparam logic [ADDR_W-1:0] CTX_CLAIM     = 22'h201004;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RAISE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN1 = 5'b00010,
        S_APPLY = 5'b00100,
        S_SCAN2 = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    typedef struct packed {
        logic latch;
        logic scan_start;
        logic apply;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_claim;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/core/plic_if.sv @@
// Request and response channel interfaces of the interrupt controller.
// Depends on plic_pkg for field widths.
interface plic_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          operation;
    logic [plic_pkg::ADDR_W-1:0]         address;
    logic [plic_pkg::DATA_W-1:0]         write_data;
    logic [plic_pkg::SRC_W-1:0]          source_id;

    modport source (output valid, operation, address, write_data, source_id, input ready);
    modport sink   (input valid, operation, address, write_data, source_id, output ready);
endinterface

interface plic_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [plic_pkg::DATA_W-1:0]         read_data;
    logic                                irq_line;

    modport source (output valid, read_data, irq_line, input ready);
    modport sink   (input valid, read_data, irq_line, output ready);
endinterface

@@ rtl/core/plic_ctrl.sv @@
// Sequencing state machine of the interrupt controller.
// Depends on plic_pkg (state, command and status types).
module plic_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  plic_pkg::sts_t  sts,
    output plic_pkg::cmd_t  cmd
);

    plic_pkg::state_t state_reg, state_next;
    logic             acc;

    assign req_ready = (state_reg == plic_pkg::S_IDLE);
    assign acc       = req_valid && req_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            plic_pkg::S_IDLE:
            begin
                if (acc)
                begin
                    cmd.latch = 1'b1;
                    if (sts.in_claim)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = plic_pkg::S_SCAN1;
                    end
                    else
                    begin
                        state_next = plic_pkg::S_APPLY;
                    end
                end
            end
            plic_pkg::S_SCAN1:
            begin
                if (sts.scan_done)
                    state_next = plic_pkg::S_APPLY;
            end
            plic_pkg::S_APPLY:
            begin
                cmd.apply      = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = plic_pkg::S_SCAN2;
            end
            plic_pkg::S_SCAN2:
            begin
                if (sts.scan_done)
                    state_next = plic_pkg::S_RESP;
            end
            plic_pkg::S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = plic_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = plic_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= plic_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // a claim read must search before it commits
    a_claim_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && sts.in_claim) |=> (state_reg == plic_pkg::S_SCAN1))
        else $error("claim did not start pre-scan");

    // a search ends only while one is awaited
    a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        sts.scan_done |-> (state_reg == plic_pkg::S_SCAN1 || state_reg == plic_pkg::S_SCAN2))
        else $error("scan done outside scan state");

    a_apply_then_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plic_pkg::S_APPLY) |=> (state_reg == plic_pkg::S_SCAN2))
        else $error("apply not followed by post-scan");

endmodule

@@ rtl/core/plic_dp.sv @@
// Datapath: register file, priority memory, arbitration scanner, output register.
// Depends on plic_pkg; driven by plic_ctrl commands.
module plic_dp #(
    parameter int unsigned NUM_SOURCES   = 128,
    parameter int unsigned PRIORITY_BITS = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    operation,
    input  logic [plic_pkg::ADDR_W-1:0]   address,
    input  logic [plic_pkg::DATA_W-1:0]   write_data,
    input  logic [plic_pkg::SRC_W-1:0]    source_id,
    input  logic                          rsp_ready,
    output logic                          rsp_valid,
    output logic [plic_pkg::DATA_W-1:0]   read_data,
    output logic                          irq_line,
    input  plic_pkg::cmd_t                cmd,
    output plic_pkg::sts_t                sts
);

    localparam int unsigned IW   = $clog2(NUM_SOURCES);
    localparam int unsigned EW   = (NUM_SOURCES + 31) / 32;
    localparam int unsigned EWW  = (EW > 1) ? $clog2(EW) : 1;
    localparam int unsigned PB   = PRIORITY_BITS;
    localparam logic [IW-1:0] LAST_ID = IW'(NUM_SOURCES - 1);
    localparam logic [plic_pkg::ADDR_W-1:0] ENABLE_END =
        plic_pkg::ADDR_W'(22'h002080 + 4 * EW);

    function automatic logic [31:0] en_mask(input logic [EWW-1:0] w);
        logic [31:0] m;
        int unsigned id;
        m = '0;
        for (int unsigned b = 0; b < 32; b++)
        begin
            id = 32 * int'(w) + b;
            if (id != 0 && id < NUM_SOURCES)
                m[b] = 1'b1;
        end
        return m;
    endfunction

    // latched request
    logic [1:0]                        op_reg;
    logic [plic_pkg::ADDR_W-1:0]       addr_reg;
    logic [plic_pkg::DATA_W-1:0]       data_reg;
    logic [plic_pkg::SRC_W-1:0]        src_reg;

    // architectural state
    logic [NUM_SOURCES-1:0]            pend_reg;
    logic [NUM_SOURCES-1:0]            insvc_reg;
    logic [NUM_SOURCES-1:0]            pvalid_reg;
    logic [EW*32-1:0]                  en_reg;
    logic [PB-1:0]                     thr_reg;
    logic [PB-1:0]                     prio_mem [NUM_SOURCES];

    // memory port
    logic [IW-1:0]                     raddr;
    logic [PB-1:0]                     rdata_q;
    logic                              rvalid_q;
    logic [PB-1:0]                     mem_prio;

    // scanner
    logic                              busy_reg;
    logic [IW-1:0]                     cnt_reg;
    logic                              cmp_valid_reg;
    logic [IW-1:0]                     cmp_id_reg;
    logic [IW-1:0]                     best_id_reg;
    logic [PB-1:0]                     best_prio_reg;
    logic                              done_reg;
    logic                              elig;

    // result
    logic [plic_pkg::DATA_W-1:0]       rd_reg;
    logic                              rd_mem_reg;
    logic                              out_valid_reg;
    logic [plic_pkg::DATA_W-1:0]       out_data_reg;
    logic                              out_irq_reg;

    // decode of latched request
    logic [plic_pkg::ADDR_W-1:0]       a;
    logic [plic_pkg::ADDR_W-3:0]       word;
    logic [plic_pkg::ADDR_W-1:0]       en_off;
    logic [EWW-1:0]                    en_w;
    logic                              is_prio, is_en, is_thr, is_claim;
    logic [IW-1:0]                     word_id;
    logic [IW-1:0]                     src_id;
    logic                              claim_hit;

    assign a        = {addr_reg[plic_pkg::ADDR_W-1:2], 2'b00};
    assign word     = addr_reg[plic_pkg::ADDR_W-1:2];
    assign word_id  = word[IW-1:0];
    assign src_id   = IW'(src_reg);
    assign en_off   = a - plic_pkg::ENABLE_BASE;
    assign en_w     = en_off[2 +: EWW];
    assign is_prio  = (32'(word) < NUM_SOURCES);
    assign is_en    = (a >= plic_pkg::ENABLE_BASE) && (a < ENABLE_END);
    assign is_thr   = (a == plic_pkg::CTX_THRESHOLD);
    assign is_claim = (a == plic_pkg::CTX_CLAIM);
    assign claim_hit = (best_id_reg != '0);

    assign sts.in_claim  = (operation == plic_pkg::OP_READ) &&
                           ({address[plic_pkg::ADDR_W-1:2], 2'b00} == plic_pkg::CTX_CLAIM);
    assign sts.scan_done = done_reg;
    assign sts.out_free  = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= operation;
            addr_reg <= address;
            data_reg <= write_data;
            src_reg  <= source_id;
        end
    end

    // priority memory: one write, one registered read
    assign raddr    = busy_reg ? cnt_reg : word_id;
    assign mem_prio = rvalid_q ? rdata_q : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.apply && op_reg == plic_pkg::OP_WRITE && is_prio && word_id != '0)
            prio_mem[word_id] <= data_reg[PB-1:0];
        rdata_q <= prio_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= '0;
            rvalid_q   <= 1'b0;
            pend_reg   <= '0;
            insvc_reg  <= '0;
            en_reg     <= '0;
            thr_reg    <= '0;
        end
        else
        begin
            rvalid_q <= pvalid_reg[raddr];
            if (cmd.apply)
            begin
                unique case (op_reg)
                    plic_pkg::OP_READ:
                    begin
                        if (is_claim && claim_hit)
                        begin
                            pend_reg[best_id_reg]  <= 1'b0;
                            insvc_reg[best_id_reg] <= 1'b1;
                        end
                    end
                    plic_pkg::OP_WRITE:
                    begin
                        if (is_prio)
                        begin
                            if (word_id != '0)
                                pvalid_reg[word_id] <= 1'b1;
                        end
                        else if (is_en)
                            en_reg[32*en_w +: 32] <= data_reg & en_mask(en_w);
                        else if (is_thr)
                            thr_reg <= data_reg[PB-1:0];
                        else if (is_claim)
                        begin
                            if (data_reg != '0 && data_reg < NUM_SOURCES)
                                insvc_reg[data_reg[IW-1:0]] <= 1'b0;
                        end
                    end
                    plic_pkg::OP_RAISE:
                    begin
                        if (src_reg != '0 && 32'(src_reg) < NUM_SOURCES &&
                            !pend_reg[src_id] && !insvc_reg[src_id])
                            pend_reg[src_id] <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // read data: direct registers at apply, priority word in the cycle after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg     <= '0;
            rd_mem_reg <= 1'b0;
        end
        else if (cmd.apply)
        begin
            rd_reg     <= '0;
            rd_mem_reg <= 1'b0;
            if (op_reg == plic_pkg::OP_READ)
            begin
                if (is_prio)
                    rd_mem_reg <= 1'b1;
                else if (is_en)
                    rd_reg <= en_reg[32*en_w +: 32];
                else if (is_thr)
                    rd_reg <= 32'(thr_reg);
                else if (is_claim)
                    rd_reg <= 32'(best_id_reg);
            end
        end
        else if (rd_mem_reg)
        begin
            rd_reg     <= 32'(mem_prio);
            rd_mem_reg <= 1'b0;
        end
    end

    // scanner: one source per cycle, compare in the cycle after the read
    assign elig = cmp_valid_reg && pend_reg[cmp_id_reg] && en_reg[cmp_id_reg] &&
                  (mem_prio > thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_id_reg    <= '0;
            best_id_reg   <= '0;
            best_prio_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= busy_reg;
            cmp_id_reg    <= cnt_reg;
            done_reg      <= cmp_valid_reg && (cmp_id_reg == LAST_ID);
            if (cmd.scan_start)
            begin
                busy_reg      <= 1'b1;
                cnt_reg       <= IW'(1);
                best_id_reg   <= '0;
                best_prio_reg <= '0;
            end
            else
            begin
                if (busy_reg)
                begin
                    cnt_reg <= cnt_reg + IW'(1);
                    if (cnt_reg == LAST_ID)
                        busy_reg <= 1'b0;
                end
                if (elig && (best_id_reg == '0 || mem_prio > best_prio_reg))
                begin
                    best_id_reg   <= cmp_id_reg;
                    best_prio_reg <= mem_prio;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= rd_reg;
            out_irq_reg  <= (best_id_reg != '0);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign irq_line  = out_irq_reg;

    a_pend_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg & insvc_reg) == '0)
        else $error("source both pending and in service");

    a_src0_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg[0] && !insvc_reg[0] && !en_reg[0])
        else $error("source zero became active");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |-> !busy_reg && !cmp_valid_reg)
        else $error("scan restarted while running");

endmodule

@@ rtl/core/platform_interrupt_controller_top.sv @@
// Platform interrupt controller top level: one supervisor context.
// Instantiates plic_ctrl and plic_dp; uses plic_pkg and the plic_if channels.
//
// Usage:
//  - req channel (valid/ready) carries one request: bus read, bus write or
//    source raise, with address, write_data and source_id.
//  - rsp channel (valid/ready) returns one response per request: read_data
//    (register word, claimed id, or zero) and irq_line (some enabled pending
//    source above threshold after this request).
//  - Registers: priority at 4*id, enable bitmap at 0x2080, threshold at
//    0x201000, claim/complete at 0x201004.
//  - Sequence: an apply step plus a scan of sources 1..NUM_SOURCES-1, one per
//    cycle through the single priority memory port; a claim read scans before
//    and after apply. One request in flight at a time.
//  - A finished response sits in an output register; the next request is
//    accepted while it waits. If the receiver stalls, the following response
//    holds in the controller until the output register frees.
//  - Reset (rst_n low, asynchronous) clears pending, in-service, enable,
//    threshold and priority valid flags; no clearing pass is needed.
module platform_interrupt_controller_top #(
    parameter int unsigned NUM_SOURCES   = 128,
    parameter int unsigned PRIORITY_BITS = 3
) (
    input logic       clk,
    input logic       rst_n,
    plic_req_if.sink  req,
    plic_rsp_if.source rsp
);

    plic_pkg::cmd_t cmd;
    plic_pkg::sts_t sts;

    // sequencer: accepts a request, orders apply and scans, loads the output
    plic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // state, priority memory, arbitration scanner and response register
    plic_dp #(
        .NUM_SOURCES   (NUM_SOURCES),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .operation  (req.operation),
        .address    (req.address),
        .write_data (req.write_data),
        .source_id  (req.source_id),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .read_data  (rsp.read_data),
        .irq_line   (rsp.irq_line),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for platform_interrupt_controller_top.
// Depends on plic_pkg, plic_req_if / plic_rsp_if and the controller RTL.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned NSRC       = 128;
    localparam int unsigned N_RANDOM   = 1100;
    localparam int unsigned CYCLE_CAP  = 1500000;
    localparam int unsigned DRAIN_WAIT = 400;
    localparam int unsigned HOLD_LEN   = 700;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    plic_req_if req ();
    plic_rsp_if rsp ();

    platform_interrupt_controller_top #(.NUM_SOURCES(NSRC), .PRIORITY_BITS(3)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // Expected response of one request
    typedef struct {
        logic [31:0] rdata;
        logic        irq;
    } rsp_exp_t;

    // One row of the directed table; fixed marks a hand-typed expectation
    typedef struct {
        plic_pkg::op_t op;
        logic [21:0] addr;
        logic [31:0] wdata;
        logic [6:0]  src;
        bit          fixed;
        logic [31:0] rdata;
        logic        irq;
    } stim_row_t;

    // Shadow copy of the controller state
    logic [2:0]  prio_mem [NSRC];
    bit [NSRC-1:0] pend_bits;
    bit [NSRC-1:0] svc_bits;
    logic [31:0] enable_mem [4];
    logic [2:0]  thresh_reg;

    rsp_exp_t    rsp_queue [$];
    int unsigned claimed_ids [$];
    int unsigned mismatches = 0;
    int unsigned rsp_seen = 0;
    int unsigned claims_won = 0;
    int unsigned cycles = 0;
    bit          stim_done = 1'b0;
    bit          hold_rsp = 1'b0;

    // Highest priority enabled pending source above threshold, lowest id wins ties
    function automatic int unsigned best_source();
        int unsigned best;
        logic [2:0]  bp;
        best = 0;
        bp = '0;
        for (int unsigned i = 1; i < NSRC; i++) begin
            if (pend_bits[i] && enable_mem[i >> 5][i & 31] && prio_mem[i] > thresh_reg) begin
                if (best == 0 || prio_mem[i] > bp) begin
                    best = i;
                    bp = prio_mem[i];
                end
            end
        end
        return best;
    endfunction

    // Apply one request to the shadow state and compute its response
    function automatic rsp_exp_t plic_predict(plic_pkg::op_t op, logic [21:0] addr_in,
                                              logic [31:0] wdata, logic [6:0] src);
        rsp_exp_t    r;
        logic [21:0] a;
        int unsigned id;
        a = {addr_in[21:2], 2'b00};
        r.rdata = '0;
        if (op == plic_pkg::OP_READ) begin
            if (a < 22'h000200) begin
                r.rdata = {29'd0, prio_mem[a >> 2]};
            end else if (a >= plic_pkg::ENABLE_BASE && a < plic_pkg::ENABLE_BASE + 22'd16) begin
                r.rdata = enable_mem[(a - plic_pkg::ENABLE_BASE) >> 2];
            end else if (a == plic_pkg::CTX_THRESHOLD) begin
                r.rdata = {29'd0, thresh_reg};
            end else if (a == plic_pkg::CTX_CLAIM) begin
                id = best_source();
                if (id != 0) begin
                    pend_bits[id] = 1'b0;
                    svc_bits[id] = 1'b1;
                    claimed_ids.push_back(id);
                    claims_won++;
                end
                r.rdata = id;
            end
        end else if (op == plic_pkg::OP_WRITE) begin
            if (a < 22'h000200) begin
                if ((a >> 2) != 0) prio_mem[a >> 2] = wdata[2:0];
            end else if (a >= plic_pkg::ENABLE_BASE && a < plic_pkg::ENABLE_BASE + 22'd16) begin
                enable_mem[(a - plic_pkg::ENABLE_BASE) >> 2] =
                    (a == plic_pkg::ENABLE_BASE) ? (wdata & 32'hFFFF_FFFE) : wdata;
            end else if (a == plic_pkg::CTX_THRESHOLD) begin
                thresh_reg = wdata[2:0];
            end else if (a == plic_pkg::CTX_CLAIM) begin
                if (wdata != 0 && wdata < NSRC) svc_bits[wdata] = 1'b0;
            end
        end else if (op == plic_pkg::OP_RAISE) begin
            if (src != 0 && !pend_bits[src] && !svc_bits[src]) pend_bits[src] = 1'b1;
        end
        r.irq = (best_source() != 0);
        return r;
    endfunction

    // Short, long or no gap between handshakes
    function automatic int unsigned pick_gap(bit busy);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (busy || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random request: mostly well-formed register traffic, some noise
    task automatic gen_random(output plic_pkg::op_t op, output logic [21:0] a,
                              output logic [31:0] d, output logic [6:0] s);
        int unsigned k;
        k = $urandom_range(0, 99);
        op = plic_pkg::OP_READ;
        a = 22'($urandom);
        d = $urandom;
        s = 7'($urandom);
        if (k < 30) begin
            op = plic_pkg::OP_RAISE;
        end else if (k < 42) begin
            op = plic_pkg::OP_WRITE;
            a = {13'd0, 7'($urandom), 2'($urandom)};
        end else if (k < 48) begin
            op = plic_pkg::OP_WRITE;
            a = plic_pkg::ENABLE_BASE + 22'($urandom_range(0, 3) * 4);
            if ($urandom_range(0, 3) != 0) d = d | $urandom;
        end else if (k < 51) begin
            op = plic_pkg::OP_WRITE;
            a = plic_pkg::CTX_THRESHOLD;
            if ($urandom_range(0, 2) != 0) d = 32'($urandom_range(0, 7));
        end else if (k < 70) begin
            a = plic_pkg::CTX_CLAIM | 22'($urandom_range(0, 3));
        end else if (k < 83) begin
            op = plic_pkg::OP_WRITE;
            a = plic_pkg::CTX_CLAIM;
            if (claimed_ids.size() != 0 && $urandom_range(0, 4) != 0) begin
                d = claimed_ids[0];
                claimed_ids.delete(0);
            end else if ($urandom_range(0, 1) != 0) begin
                d = $urandom_range(0, 127);
            end
        end else if (k < 91) begin
            case ($urandom_range(0, 2))
                0: a = {13'd0, 7'($urandom), 2'($urandom)};
                1: a = plic_pkg::ENABLE_BASE + 22'($urandom_range(0, 5) * 4);
                default: a = plic_pkg::CTX_THRESHOLD;
            endcase
        end else if (k < 95) begin
            op = plic_pkg::OP_NONE;
        end else begin
            op = (k < 97) ? plic_pkg::OP_READ : plic_pkg::OP_WRITE;
        end
    endtask

    // Drive one request and wait for its acceptance; predict on acceptance
    task automatic send_req(plic_pkg::op_t op, logic [21:0] a, logic [31:0] d,
                            logic [6:0] s, bit fixed, rsp_exp_t fx, int unsigned gap);
        rsp_exp_t e;
        if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.operation  <= op;
        req.address    <= a;
        req.write_data <= d;
        req.source_id  <= s;
        forever begin
            @(negedge clk);
            if (req.ready) break;
            @(posedge clk);
        end
        @(posedge clk);
        e = plic_predict(op, a, d, s);
        rsp_queue.push_back(fixed ? fx : e);
    endtask

    // Directed table: reset values, extremes, source zero, claim rules
    stim_row_t dir_rows [] = '{
        '{plic_pkg::OP_READ,  22'h000004, 32'h0, 7'd0, 1, 32'h0, 1'b0},
        '{plic_pkg::OP_READ,  plic_pkg::CTX_CLAIM, 32'h0, 7'd0, 1, 32'h0, 1'b0},
        '{plic_pkg::OP_WRITE, 22'h000000, 32'hFFFF_FFFF, 7'd0, 1, 32'h0, 1'b0},
        '{plic_pkg::OP_READ,  22'h000000, 32'h0, 7'd0, 1, 32'h0, 1'b0},
        '{plic_pkg::OP_WRITE, 22'h000004, 32'hFFFF_FFFF, 7'd0, 1, 32'h0, 1'b0},
        '{plic_pkg::OP_READ,  22'h000007, 32'h0, 7'd0, 1, 32'h7, 1'b0},
        '{plic_pkg::OP_WRITE, 22'h0001FC, 32'h0000_0005, 7'd0, 1, 32'h0, 1'b0},
        '{plic_pkg::OP_WRITE, plic_pkg::ENABLE_BASE, 32'hFFFF_FFFF, 7'd0, 1, 32'h0, 1'b0},
        '{plic_pkg::OP_READ,  plic_pkg::ENABLE_BASE, 32'h0, 7'd0, 1, 32'hFFFF_FFFE, 1'b0},
        '{plic_pkg::OP_WRITE, 22'h00208C, 32'hFFFF_FFFF, 7'd0, 1, 32'h0, 1'b0},
        '{plic_pkg::OP_RAISE, 22'h000000, 32'h0, 7'd0, 1, 32'h0, 1'b0},
        '{plic_pkg::OP_RAISE, 22'h000000, 32'h0, 7'd127, 1, 32'h0, 1'b1},
        '{plic_pkg::OP_RAISE, 22'h000000, 32'h0, 7'd127, 1, 32'h0, 1'b1},
        '{plic_pkg::OP_RAISE, 22'h3FFFFF, 32'hFFFF_FFFF, 7'd1, 0, 32'h0, 1'b0},
        '{plic_pkg::OP_READ,  plic_pkg::CTX_CLAIM, 32'h0, 7'd0, 1, 32'd1, 1'b1},
        '{plic_pkg::OP_RAISE, 22'h000000, 32'h0, 7'd1, 0, 32'h0, 1'b0},
        '{plic_pkg::OP_READ,  plic_pkg::CTX_CLAIM, 32'h0, 7'd0, 1, 32'd127, 1'b0},
        '{plic_pkg::OP_READ,  plic_pkg::CTX_CLAIM, 32'h0, 7'd0, 1, 32'h0, 1'b0},
        '{plic_pkg::OP_WRITE, plic_pkg::CTX_CLAIM, 32'd0, 7'd0, 0, 32'h0, 1'b0},
        '{plic_pkg::OP_WRITE, plic_pkg::CTX_CLAIM, 32'd1, 7'd0, 0, 32'h0, 1'b0},
        '{plic_pkg::OP_WRITE, plic_pkg::CTX_THRESHOLD, 32'hFFFF_FFFF, 7'd0, 1, 32'h0, 1'b0},
        '{plic_pkg::OP_READ,  plic_pkg::CTX_THRESHOLD, 32'h0, 7'd0, 1, 32'h7, 1'b0},
        '{plic_pkg::OP_READ,  22'h3FFFFC, 32'h0, 7'd0, 1, 32'h0, 1'b0},
        '{plic_pkg::OP_NONE,  plic_pkg::CTX_CLAIM, 32'hFFFF_FFFF, 7'd127, 1, 32'h0, 1'b0},
        '{plic_pkg::OP_WRITE, plic_pkg::CTX_THRESHOLD, 32'h0, 7'd0, 0, 32'h0, 1'b0}
    };

    // Sender: directed rows, then random traffic with one full drain pause
    initial begin : sender
        plic_pkg::op_t op;
        logic [21:0] a;
        logic [31:0] d;
        logic [6:0]  s;
        rsp_exp_t    fx;
        bit          busy;
        for (int i = 0; i < NSRC; i++) prio_mem[i] = '0;
        for (int i = 0; i < 4; i++) enable_mem[i] = '0;
        pend_bits = '0;
        svc_bits = '0;
        thresh_reg = '0;
        req.valid      = 1'b0;
        req.operation  = plic_pkg::OP_NONE;
        req.address    = '0;
        req.write_data = '0;
        req.source_id  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i]) begin
            fx.rdata = dir_rows[i].rdata;
            fx.irq = dir_rows[i].irq;
            send_req(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].wdata,
                     dir_rows[i].src, dir_rows[i].fixed, fx, pick_gap(1'b0));
        end
        busy = 1'b0;
        for (int n = 0; n < N_RANDOM; n++) begin
            // Bursts with no idling now and then
            if (n % 100 == 0) busy = ($urandom_range(0, 2) == 0);
            if (n == 400) hold_rsp = 1'b1;
            if (n == 700) begin
                // Sender pause: let every outstanding response drain
                req.valid <= 1'b0;
                while (rsp_queue.size() != 0) @(posedge clk);
            end
            gen_random(op, a, d, s);
            send_req(op, a, d, s, 1'b0, fx, pick_gap(busy));
        end
        req.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random ready, plus one long hold-off counted here
    initial begin : receiver
        int unsigned gap;
        bit          busy;
        rsp.ready = 1'b0;
        busy = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_rsp) begin
                hold_rsp = 1'b0;
                rsp.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            if ($urandom_range(0, 199) == 0) busy = ~busy;
            gap = pick_gap(busy);
            if (gap != 0) begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    // Response checker: handshake seen at the falling edge completes next rising edge
    always @(negedge clk) begin
        rsp_exp_t e;
        if (rst_n && rsp.valid && rsp.ready) begin
            rsp_seen++;
            if (rsp_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected response rd=%h irq=%b", rsp.read_data,
                             rsp.irq_line);
            end else begin
                e = rsp_queue.pop_front();
                if (rsp.read_data !== e.rdata || rsp.irq_line !== e.irq) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: response %0d exp rd=%h irq=%b got rd=%h irq=%b",
                                 rsp_seen, e.rdata, e.irq, rsp.read_data, rsp.irq_line);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("ERROR: timeout with %0d responses outstanding", rsp_queue.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // End of run: drain, settle, report
    initial begin : finisher
        wait (stim_done);
        while (rsp_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (rsp_queue.size() != 0) mismatches++;
        $display("Covered %0d responses, %0d successful claims, %0d mismatches.",
                 rsp_seen, claims_won, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ platform_interrupt_controller_top.f @@
rtl/core/plic_pkg.sv
rtl/core/plic_if.sv
rtl/core/plic_ctrl.sv
rtl/core/plic_dp.sv
rtl/core/platform_interrupt_controller_top.sv
bench/tb.sv
